// ===== hw/rtl/assert_macros.svh =====
// assertion macros used by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define AN_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define AN_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define AN_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AN_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/aesnia_pkg.sv =====
// ----------------------------------------------------------------------------
// aesnia_pkg
// types, constants and aes helper functions for the integrity mac block
// ----------------------------------------------------------------------------
package aesnia_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BEARER   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIR      = 3'd3;

    localparam logic [4:0] FILL_FULL     = 5'd16;
    localparam logic [4:0] FILL_PREAMBLE = 5'd8;
    localparam logic [3:0] LAST_ROUND    = 4'd10;
    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [7:0] RB_CONST      = 8'h87;
    localparam logic [7:0] RCON_FIRST    = 8'h01;

    typedef enum logic [1:0] {
        JOB_PLAIN = 2'd0,
        JOB_K1    = 2'd1,
        JOB_K2    = 2'd2
    } job_kind_t;

    typedef enum logic [1:0] {
        EN_IDLE = 2'd0,
        EN_RUN  = 2'd1,
        EN_FIN  = 2'd2
    } eng_state_t;

    typedef struct packed {
        logic [127:0] blk;
        job_kind_t    kind;
        logic         chk;
        logic [31:0]  rx;
        logic         saw;
    } job_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] xtime(input logic [7:0] x);
        return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic logic [7:0] get_byte(input logic [127:0] v, input int k);
        return v[127-8*k -: 8];
    endfunction

    // one aes round: subbytes, shiftrows and mixcolumns unless final
    function automatic logic [127:0] aes_round(input logic [127:0] s, input logic fin);
        logic [7:0]   t [16];
        logic [7:0]   a0, a1, a2, a3, all;
        logic [127:0] r;
        for (int c = 0; c < 4; c++) begin
            for (int j = 0; j < 4; j++) begin
                t[j + 4*c] = SBOX[get_byte(s, j + 4*((c + j) & 3))];
            end
        end
        if (!fin) begin
            for (int c = 0; c < 4; c++) begin
                a0  = t[4*c];
                a1  = t[4*c+1];
                a2  = t[4*c+2];
                a3  = t[4*c+3];
                all = a0 ^ a1 ^ a2 ^ a3;
                t[4*c]   = a0 ^ all ^ xtime(a0 ^ a1);
                t[4*c+1] = a1 ^ all ^ xtime(a1 ^ a2);
                t[4*c+2] = a2 ^ all ^ xtime(a2 ^ a3);
                t[4*c+3] = a3 ^ all ^ xtime(a3 ^ a0);
            end
        end
        for (int k = 0; k < 16; k++) begin
            r[127-8*k -: 8] = t[k];
        end
        return r;
    endfunction

    // next round key from the current one
    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rcon);
        logic [31:0] tmp, n0, n1, n2, n3;
        tmp = {SBOX[rk[23:16]] ^ rcon, SBOX[rk[15:8]], SBOX[rk[7:0]], SBOX[rk[31:24]]};
        n0  = rk[127:96] ^ tmp;
        n1  = rk[95:64] ^ n0;
        n2  = rk[63:32] ^ n1;
        n3  = rk[31:0] ^ n2;
        return {n0, n1, n2, n3};
    endfunction

    function automatic logic [127:0] dbl(input logic [127:0] v);
        return {v[126:0], 1'b0} ^ {120'd0, (v[127] ? RB_CONST : 8'h00)};
    endfunction

endpackage

// ===== hw/rtl/aes_cmac_integrity_mac.sv =====
// ----------------------------------------------------------------------------
// aes_cmac_integrity_mac
// 128-nia2 integrity mac (aes-128 cmac truncated to 32 bits)
// ----------------------------------------------------------------------------
// usage: configure key, bearer and direction through the write port while
// idle. message bytes enter one per transaction on the s_ channel, with
// frame_count taken on the first transaction and check_mode/received_mac
// on the one marked last_item. one result transaction (mac, mac_ok) leaves
// on the m_ channel for every message.
// throughput: one byte per cycle while the job queue has room and no final
// block is held waiting for it. the aes engine runs one round per cycle,
// plus a load and a finish step per 16-byte block, so long messages stream
// at full rate; a message costs at least one block, so very short messages
// are limited by the engine. m_valid follows the final block's aes pass;
// a last transaction whose byte starts a new block after a full one costs
// one more aes pass and stalls the input until the final block is queued.
// reset: the queue and message state clear; the engine derives the subkeys
// before its first job, and again after every key write.
// a stalled receiver holds the result register; the engine then waits with
// the next final block and the queue and input fill up behind it.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module aes_cmac_integrity_mac #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [aesnia_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [aesnia_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [7:0]                        s_data_byte,
    input  logic                              s_has_byte,
    input  logic                              s_last_item,
    input  logic [31:0]                       s_frame_count,
    input  logic                              s_check_mode,
    input  logic [31:0]                       s_received_mac,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [31:0]                       m_mac,
    output logic                              m_mac_ok
);

    logic [63:0]      key_high_reg, key_low_reg;
    logic [4:0]       bearer_reg;
    logic             dir_reg;
    logic             key_wr;
    logic             q_push, q_pop, q_full, q_empty;
    aesnia_pkg::job_t q_in, q_out;

    assign key_wr = cfg_wr_en &&
                    (cfg_index == aesnia_pkg::REG_KEY_HIGH ||
                     cfg_index == aesnia_pkg::REG_KEY_LOW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_high_reg <= 64'd0;
            key_low_reg  <= 64'd0;
            bearer_reg   <= 5'd0;
            dir_reg      <= 1'b0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                aesnia_pkg::REG_KEY_HIGH: key_high_reg <= cfg_data;
                aesnia_pkg::REG_KEY_LOW:  key_low_reg  <= cfg_data;
                aesnia_pkg::REG_BEARER:   bearer_reg   <= cfg_data[4:0];
                aesnia_pkg::REG_DIR:      dir_reg      <= cfg_data[0];
                default: ;
            endcase
        end
    end

    aesnia_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_data_byte    (s_data_byte),
        .s_has_byte     (s_has_byte),
        .s_last_item    (s_last_item),
        .s_frame_count  (s_frame_count),
        .s_check_mode   (s_check_mode),
        .s_received_mac (s_received_mac),
        .bearer         (bearer_reg),
        .link_direction (dir_reg),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_in)
    );

    aesnia_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    aesnia_engine u_engine (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .key      ({key_high_reg, key_low_reg}),
        .key_wr   (key_wr),
        .q_empty  (q_empty),
        .q_data   (q_out),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_mac    (m_mac),
        .m_mac_ok (m_mac_ok)
    );

    `AN_ASSERT_IMP(a_no_push_full, aclk, aresetn, q_push && q_full, q_pop)
    `AN_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, q_pop, !q_empty)
    `AN_ASSERT_NXT(a_ready_room, aclk, aresetn, s_valid && s_ready && s_last_item, !s_ready || !q_empty)

endmodule

// ===== hw/rtl/aesnia_front.sv =====
// ----------------------------------------------------------------------------
// aesnia_front
// accepts message bytes, builds preamble and blocks, queues aes jobs
// ----------------------------------------------------------------------------
module aesnia_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_data_byte,
    input  logic              s_has_byte,
    input  logic              s_last_item,
    input  logic [31:0]       s_frame_count,
    input  logic              s_check_mode,
    input  logic [31:0]       s_received_mac,
    input  logic [4:0]        bearer,
    input  logic              link_direction,
    input  logic              q_full,
    output logic              q_push,
    output aesnia_pkg::job_t  q_data
);

    logic         in_msg_reg, in_msg_next;
    logic [4:0]   fill_reg, fill_next;
    logic [127:0] blk_reg, blk_next;
    logic         saw_reg, saw_next;
    logic         pend_reg, pend_next;
    logic         pchk_reg, pchk_next;
    logic [31:0]  prx_reg, prx_next;

    logic         acc;
    logic [127:0] b0, b1;
    logic [4:0]   f0, f2;
    logic [3:0]   idx;
    logic         sw0;

    function automatic aesnia_pkg::job_t final_job(input logic [127:0] b, input logic [4:0] f,
                                                   input logic chk, input logic [31:0] rx,
                                                   input logic sw);
        aesnia_pkg::job_t j;
        j.chk = chk;
        j.rx  = rx;
        j.saw = sw;
        if (f == aesnia_pkg::FILL_FULL) begin
            j.blk  = b;
            j.kind = aesnia_pkg::JOB_K1;
        end else begin
            j.kind = aesnia_pkg::JOB_K2;
            for (int k = 0; k < 16; k++) begin
                if (5'(k) < f) begin
                    j.blk[127-8*k -: 8] = b[127-8*k -: 8];
                end else if (5'(k) == f) begin
                    j.blk[127-8*k -: 8] = aesnia_pkg::PAD_BYTE;
                end else begin
                    j.blk[127-8*k -: 8] = 8'h00;
                end
            end
        end
        return j;
    endfunction

    assign s_ready = !pend_reg && !q_full;
    assign acc     = s_valid && s_ready;

    always_comb begin
        in_msg_next = in_msg_reg;
        fill_next   = fill_reg;
        blk_next    = blk_reg;
        saw_next    = saw_reg;
        pend_next   = pend_reg;
        pchk_next   = pchk_reg;
        prx_next    = prx_reg;
        q_push      = 1'b0;
        q_data      = final_job(blk_reg, fill_reg, pchk_reg, prx_reg, saw_reg);

        b0  = in_msg_reg ? blk_reg :
              {s_frame_count, bearer, link_direction, 2'b00, 24'd0, 64'd0};
        f0  = in_msg_reg ? fill_reg : aesnia_pkg::FILL_PREAMBLE;
        sw0 = in_msg_reg ? saw_reg : 1'b0;
        idx = (f0 == aesnia_pkg::FILL_FULL) ? 4'd0 : f0[3:0];
        b1  = b0;
        f2  = f0;

        if (pend_reg) begin
            if (!q_full) begin
                q_push    = 1'b1;
                pend_next = 1'b0;
            end
        end else if (acc) begin
            if (s_has_byte) begin
                for (int k = 0; k < 16; k++) begin
                    if (idx == 4'(k)) begin
                        b1[127-8*k -: 8] = s_data_byte;
                    end
                end
                f2 = {1'b0, idx} + 5'd1;
                if (f0 == aesnia_pkg::FILL_FULL) begin
                    q_push      = 1'b1;
                    q_data.blk  = b0;
                    q_data.kind = aesnia_pkg::JOB_PLAIN;
                    q_data.chk  = 1'b0;
                    q_data.rx   = 32'd0;
                    q_data.saw  = 1'b0;
                end
            end
            blk_next    = b1;
            fill_next   = f2;
            saw_next    = sw0 || s_has_byte;
            in_msg_next = !s_last_item;
            if (s_last_item) begin
                if (q_push) begin
                    pend_next = 1'b1;
                    pchk_next = s_check_mode;
                    prx_next  = s_received_mac;
                end else begin
                    q_push = 1'b1;
                    q_data = final_job(b1, f2, s_check_mode, s_received_mac,
                                       sw0 || s_has_byte);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_msg_reg <= 1'b0;
            fill_reg   <= 5'd0;
            saw_reg    <= 1'b0;
            pend_reg   <= 1'b0;
        end else begin
            in_msg_reg <= in_msg_next;
            fill_reg   <= fill_next;
            saw_reg    <= saw_next;
            pend_reg   <= pend_next;
        end
        blk_reg  <= blk_next;
        pchk_reg <= pchk_next;
        prx_reg  <= prx_next;
    end

endmodule

// ===== hw/rtl/aesnia_fifo.sv =====
// ----------------------------------------------------------------------------
// aesnia_fifo
// short job queue between the byte front end and the aes engine
// ----------------------------------------------------------------------------
module aesnia_fifo #(
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  aesnia_pkg::job_t push_data,
    output logic             full,
    input  logic             pop,
    output aesnia_pkg::job_t pop_data,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    aesnia_pkg::job_t mem_reg [DEPTH];
    logic [PW-1:0]    wptr_reg, wptr_next, rptr_reg, rptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;

    assign full     = (cnt_reg == CW'(DEPTH));
    assign empty    = (cnt_reg == '0);
    assign pop_data = mem_reg[rptr_reg];

    always_comb begin
        wptr_next = wptr_reg;
        rptr_next = rptr_reg;
        cnt_next  = cnt_reg;
        if (push) begin
            wptr_next = (wptr_reg == PW'(DEPTH - 1)) ? '0 : wptr_reg + PW'(1);
        end
        if (pop) begin
            rptr_next = (rptr_reg == PW'(DEPTH - 1)) ? '0 : rptr_reg + PW'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
        if (push) begin
            mem_reg[wptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/aesnia_engine.sv =====
// ----------------------------------------------------------------------------
// aesnia_engine
// iterative aes-128 with cbc chaining, subkey derivation and mac output
// ----------------------------------------------------------------------------
module aesnia_engine (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [127:0]     key,
    input  logic             key_wr,
    input  logic             q_empty,
    input  aesnia_pkg::job_t q_data,
    output logic             q_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_mac,
    output logic             m_mac_ok
);

    aesnia_pkg::eng_state_t state_reg, state_next;
    logic         sub_pend_reg, sub_pend_next;
    logic         job_sub_reg, job_sub_next;
    aesnia_pkg::job_t job_reg, job_next;
    logic [127:0] s_reg, s_next;
    logic [127:0] rk_reg, rk_next;
    logic [7:0]   rcon_reg, rcon_next;
    logic [3:0]   rnd_reg, rnd_next;
    logic [127:0] chain_reg, chain_next;
    logic [127:0] k1_reg, k1_next, k2_reg, k2_next;
    logic         ov_reg, ov_next;
    logic [31:0]  mac_reg, mac_next;
    logic         ok_reg, ok_next;
    logic [127:0] sub_sel;
    logic [127:0] rk_step;

    assign m_valid  = ov_reg;
    assign m_mac    = mac_reg;
    assign m_mac_ok = ok_reg;

    always_comb begin
        state_next    = state_reg;
        sub_pend_next = sub_pend_reg;
        job_sub_next  = job_sub_reg;
        job_next      = job_reg;
        s_next        = s_reg;
        rk_next       = rk_reg;
        rcon_next     = rcon_reg;
        rnd_next      = rnd_reg;
        chain_next    = chain_reg;
        k1_next       = k1_reg;
        k2_next       = k2_reg;
        ov_next       = ov_reg && !m_ready;
        mac_next      = mac_reg;
        ok_next       = ok_reg;
        q_pop         = 1'b0;
        rk_step       = aesnia_pkg::key_step(rk_reg, rcon_reg);

        case (q_data.kind)
            aesnia_pkg::JOB_K1: sub_sel = k1_reg;
            aesnia_pkg::JOB_K2: sub_sel = k2_reg;
            default:            sub_sel = 128'd0;
        endcase

        unique case (state_reg)
            aesnia_pkg::EN_IDLE: begin
                if (sub_pend_reg) begin
                    sub_pend_next = 1'b0;
                    job_sub_next  = 1'b1;
                    s_next        = key;
                    rk_next       = key;
                    rcon_next     = aesnia_pkg::RCON_FIRST;
                    rnd_next      = 4'd1;
                    state_next    = aesnia_pkg::EN_RUN;
                end else if (!q_empty) begin
                    q_pop        = 1'b1;
                    job_sub_next = 1'b0;
                    job_next     = q_data;
                    s_next       = q_data.blk ^ chain_reg ^ sub_sel ^ key;
                    rk_next      = key;
                    rcon_next    = aesnia_pkg::RCON_FIRST;
                    rnd_next     = 4'd1;
                    state_next   = aesnia_pkg::EN_RUN;
                end
            end
            aesnia_pkg::EN_RUN: begin
                s_next    = aesnia_pkg::aes_round(s_reg, rnd_reg == aesnia_pkg::LAST_ROUND)
                            ^ rk_step;
                rk_next   = rk_step;
                rcon_next = aesnia_pkg::xtime(rcon_reg);
                rnd_next  = rnd_reg + 4'd1;
                if (rnd_reg == aesnia_pkg::LAST_ROUND) begin
                    state_next = aesnia_pkg::EN_FIN;
                end
            end
            aesnia_pkg::EN_FIN: begin
                if (job_sub_reg) begin
                    k1_next    = aesnia_pkg::dbl(s_reg);
                    k2_next    = aesnia_pkg::dbl(aesnia_pkg::dbl(s_reg));
                    state_next = aesnia_pkg::EN_IDLE;
                end else if (job_reg.kind == aesnia_pkg::JOB_PLAIN) begin
                    chain_next = s_reg;
                    state_next = aesnia_pkg::EN_IDLE;
                end else if (!ov_reg || m_ready) begin
                    ov_next    = 1'b1;
                    mac_next   = s_reg[127:96];
                    ok_next    = !job_reg.chk || (job_reg.saw && (s_reg[127:96] == job_reg.rx));
                    chain_next = 128'd0;
                    state_next = aesnia_pkg::EN_IDLE;
                end
            end
            default: begin
                state_next = aesnia_pkg::EN_IDLE;
            end
        endcase

        if (key_wr) begin
            sub_pend_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= aesnia_pkg::EN_IDLE;
            sub_pend_reg <= 1'b1;
            chain_reg    <= 128'd0;
            ov_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            sub_pend_reg <= sub_pend_next;
            chain_reg    <= chain_next;
            ov_reg       <= ov_next;
        end
        job_sub_reg <= job_sub_next;
        job_reg     <= job_next;
        s_reg       <= s_next;
        rk_reg      <= rk_next;
        rcon_reg    <= rcon_next;
        rnd_reg     <= rnd_next;
        k1_reg      <= k1_next;
        k2_reg      <= k2_next;
        mac_reg     <= mac_next;
        ok_reg      <= ok_next;
    end

endmodule
